FILE: rtl/sdwc_pkg.sv
`timescale 1ns / 1ps
package sdwc_pkg;

  localparam int FREQ_W     = 32;
  localparam int INT_W      = 9;
  localparam int REM_W      = 24;
  localparam int HALF_W     = 10;
  localparam int FRAC_OUT_W = 2 * HALF_W;

  // reference in hertz, fits the remainder width
  localparam logic [FREQ_W-1:0] REF_HZ = 32'd15000000;

  localparam int FRAC_BITS_DEF = 20;

  // quotient: 9 restoring steps, 3 per stage
  localparam int QUOT_STAGES     = 3;
  localparam int QBITS_PER_STAGE = 3;

  // fraction: 4 restoring steps per stage
  localparam int FSTEPS_PER_STAGE = 4;

endpackage

FILE: rtl/sdwc_quot_stage.sv
`timescale 1ns / 1ps
module sdwc_quot_stage #(
  parameter int FIRST_BIT = 8,
  parameter int NBITS     = 3
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [sdwc_pkg::FREQ_W-1:0] rem_in,
  input  logic [sdwc_pkg::INT_W-1:0]  quot_in,
  output logic [sdwc_pkg::FREQ_W-1:0] rem_out,
  output logic [sdwc_pkg::INT_W-1:0]  quot_out
);
  import sdwc_pkg::*;

  logic [FREQ_W-1:0] rem_c;
  logic [INT_W-1:0]  quot_c;

  // restoring steps against REF_HZ << bit, high bit first
  always_comb begin
    logic [FREQ_W-1:0] cmp;
    rem_c  = rem_in;
    quot_c = quot_in;
    cmp    = '0;
    for (int i = 0; i < NBITS; i++) begin
      cmp = REF_HZ << (FIRST_BIT - i);
      if (rem_c >= cmp) begin
        rem_c                  = rem_c - cmp;
        quot_c[FIRST_BIT - i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_out  <= rem_c;
      quot_out <= quot_c;
    end
  end

endmodule

FILE: rtl/sdwc_frac_stage.sv
`timescale 1ns / 1ps
module sdwc_frac_stage #(
  parameter int FRAC_BITS  = sdwc_pkg::FRAC_BITS_DEF,
  parameter int FIRST_STEP = 0,
  parameter int NSTEPS     = 4
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [sdwc_pkg::REM_W-1:0] rem_in,
  input  logic [FRAC_BITS-1:0]       word_in,
  input  logic [sdwc_pkg::INT_W-1:0] quot_in,
  output logic [sdwc_pkg::REM_W-1:0] rem_out,
  output logic [FRAC_BITS-1:0]       word_out,
  output logic [sdwc_pkg::INT_W-1:0] quot_out
);
  import sdwc_pkg::*;

  logic [REM_W-1:0]     rem_c;
  logic [FRAC_BITS-1:0] word_c;

  // compare value halves each step; strict compare sets the bit
  always_comb begin
    logic [REM_W-1:0] cmp;
    rem_c  = rem_in;
    word_c = word_in;
    cmp    = '0;
    for (int i = 0; i < NSTEPS; i++) begin
      if (FIRST_STEP + i < FRAC_BITS) begin
        cmp    = REM_W'(REF_HZ >> (FIRST_STEP + i + 1));
        word_c = {word_c[FRAC_BITS-2:0], 1'b0};
        if (rem_c > cmp) begin
          word_c[0] = 1'b1;
          rem_c     = rem_c - cmp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem_out  <= rem_c;
      word_out <= word_c;
      quot_out <= quot_in;
    end
  end

endmodule

FILE: rtl/synth_divider_word_calc.sv
`timescale 1ns / 1ps
// Fractional-N divider word calculation. Each freq_hz beat gives one result
// beat: int_divider = freq_hz / 15 MHz, and a FRAC_BITS-wide fractional word
// from the remainder, presented as frac_high (word bits 19..10) and frac_low
// (word bits 9..0). A new beat is taken every cycle while in_stall is low.
// The result is registered through three stages of three restoring quotient
// steps each, then stages of four fraction steps each; the depth of one stage
// is set by those chained compare-subtracts. Stall from the output ripples
// back stage by stage, so a bubble is filled and nothing is dropped or
// repeated. No state is kept between beats.
module synth_divider_word_calc #(
  parameter int FRAC_BITS = sdwc_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sdwc_pkg::FREQ_W-1:0] freq_hz,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sdwc_pkg::INT_W-1:0]  int_divider,
  output logic [sdwc_pkg::HALF_W-1:0] frac_high,
  output logic [sdwc_pkg::HALF_W-1:0] frac_low
);
  import sdwc_pkg::*;

  localparam int NQ    = QUOT_STAGES;
  localparam int NF    = (FRAC_BITS + FSTEPS_PER_STAGE - 1) / FSTEPS_PER_STAGE;
  localparam int NS    = NQ + NF;
  localparam int EXT_W = FRAC_BITS + FRAC_OUT_W;

  // per-stage valid bits and stage-by-stage ready chain
  logic [NS-1:0] valid;
  logic [NS:0]   ready;
  logic [NS-1:0] valid_in;

  assign ready[NS] = ~out_stall;
  assign valid_in  = {valid[NS-2:0], in_valid};

  generate
    for (genvar s = 0; s < NS; s++) begin : g_rdy
      assign ready[s] = ~valid[s] | ready[s+1];
    end
  endgenerate

  assign in_stall = ~ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (ready[s]) begin
          valid[s] <= valid_in[s];
        end
      end
    end
  end

  // quotient stages
  logic [FREQ_W-1:0] q_rem  [0:NQ];
  logic [INT_W-1:0]  q_quot [0:NQ];

  assign q_rem[0]  = freq_hz;
  assign q_quot[0] = '0;

  generate
    for (genvar j = 0; j < NQ; j++) begin : g_quot
      sdwc_quot_stage #(
        .FIRST_BIT(INT_W - 1 - j * QBITS_PER_STAGE),
        .NBITS    (QBITS_PER_STAGE)
      ) u_stage (
        .clk     (clk),
        .load    (ready[j] & valid_in[j]),
        .rem_in  (q_rem[j]),
        .quot_in (q_quot[j]),
        .rem_out (q_rem[j+1]),
        .quot_out(q_quot[j+1])
      );
    end
  endgenerate

  // fraction stages; remainder is now below the reference
  logic [REM_W-1:0]     f_rem  [0:NF];
  logic [FRAC_BITS-1:0] f_word [0:NF];
  logic [INT_W-1:0]     f_quot [0:NF];

  assign f_rem[0]  = q_rem[NQ][REM_W-1:0];
  assign f_word[0] = '0;
  assign f_quot[0] = q_quot[NQ];

  generate
    for (genvar k = 0; k < NF; k++) begin : g_frac
      sdwc_frac_stage #(
        .FRAC_BITS (FRAC_BITS),
        .FIRST_STEP(k * FSTEPS_PER_STAGE),
        .NSTEPS    (FSTEPS_PER_STAGE)
      ) u_stage (
        .clk     (clk),
        .load    (ready[NQ+k] & valid_in[NQ+k]),
        .rem_in  (f_rem[k]),
        .word_in (f_word[k]),
        .quot_in (f_quot[k]),
        .rem_out (f_rem[k+1]),
        .word_out(f_word[k+1]),
        .quot_out(f_quot[k+1])
      );
    end
  endgenerate

  // outputs straight from the last stage register; narrow words read zero above,
  // wide words drop bits above 19
  logic [EXT_W-1:0] word_ext;

  assign word_ext    = EXT_W'(f_word[NF]);
  assign out_valid   = valid[NS-1];
  assign int_divider = f_quot[NF];
  assign frac_high   = word_ext[FRAC_OUT_W-1:HALF_W];
  assign frac_low    = word_ext[HALF_W-1:0];

  // remainder of the last stage is not needed
  logic unused_rem;
  assign unused_rem = ^f_rem[NF];

endmodule
